// File: hdl/cfba_pkg.sv
// shared types and codes for the chained free block allocator
// no dependencies; used by chained_free_block_allocator
`default_nettype none

package cfba_pkg;

  localparam int unsigned BLK_W  = 32;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned WIDX_W = 6;

  typedef logic [BLK_W-1:0] blk_t;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_REFILL = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANT    = 3'd0,
    KIND_NO_SPACE = 3'd1,
    KIND_REQUEST  = 3'd2,
    KIND_SPILL    = 3'd3,
    KIND_FREED    = 3'd4,
    KIND_BAD_FREE = 3'd5,
    KIND_REJECT   = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC_CHK,
    ST_ALLOC_RD,
    ST_FREE_CHK,
    ST_SPILL_CNT,
    ST_SPILL_RD,
    ST_FREE_PUSH,
    ST_REFILL,
    ST_REJECT
  } state_t;

  typedef enum logic {
    REG_FIRST_DATA_BLOCK = 1'b0,
    REG_VOLUME_BLOCKS    = 1'b1
  } reg_idx_t;

endpackage

`default_nettype wire

// File: hdl/chained_free_block_allocator.sv
// Chained free block allocator. An in-core stack of up to STACK_SIZE free block
// numbers lives in one ram with a registered read; a small sequencer reads,
// checks and writes it back one item at a time. An allocate checks the count,
// then reads the top entry and pops again for each out-of-range entry skipped;
// a free checks the block number and pushes it, a free on a full stack first
// streams the count and the entries out as spill words (one ram read per entry),
// a refill word is loaded into the count or the stack, and a rejected item is
// answered with a reject. Each result word passes through the output register;
// a stalled output holds the sequencer in place.
// Depends on cfba_pkg and cfba_ram.
`default_nettype none

module chained_free_block_allocator #(
  parameter int unsigned STACK_SIZE = 50
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [31:0] in_block_num,
  input  wire logic [31:0] in_refill_word,
  input  wire logic        in_read_ok,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [31:0]      out_block_num_res,
  output logic [31:0]      out_word,
  output logic [5:0]       out_word_index,
  output logic [31:0]      out_total_free,
  output logic             out_dirty,
  output logic             out_last
);

  localparam int unsigned IDX_W = (STACK_SIZE > 1) ? $clog2(STACK_SIZE) : 1;
  localparam int unsigned POS_W = $clog2(STACK_SIZE + 1);
  localparam logic [31:0] SS32  = 32'(STACK_SIZE);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(STACK_SIZE);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STACK_SIZE - 1);

  cfba_pkg::state_t state_r, state_nxt;

  logic [31:0] first_blk_r, vol_blk_r;
  logic [31:0] count_r, count_nxt;
  logic [31:0] total_r, total_nxt;
  logic        mod_r, mod_nxt;
  logic        pend_r, pend_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0] pblk_r, pblk_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // latched input word
  logic [31:0] bn_r, rw_r;
  logic        ok_r;

  // output register
  logic        out_valid_r;
  logic [2:0]  kind_r;
  logic [31:0] blk_res_r, word_r, tot_out_r;
  logic [5:0]  widx_r;
  logic        dirty_r, last_r;

  // ram ports
  logic             m_we, m_re;
  logic [IDX_W-1:0] m_waddr, m_raddr;
  logic [31:0]      m_wdata, m_rdata;

  // result being produced this cycle
  logic              emit;
  cfba_pkg::kind_t   e_kind;
  logic [31:0]       e_blk, e_word, e_tot;
  logic [5:0]        e_widx;
  logic              e_dirty, e_last;
  logic              advance;

  logic [31:0] cnt_dec;
  logic        cnt_nonpos, cnt_over, cnt_full;
  logic        rd_oor, bn_oor, rfl_nonpos;

  cfba_ram #(
    .WIDTH  (32),
    .DEPTH  (STACK_SIZE),
    .ADDR_W (IDX_W)
  ) u_stack (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .re    (m_re),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  assign cnt_dec    = count_r - 32'd1;
  assign cnt_nonpos = (count_r == 32'd0) || count_r[31];
  assign cnt_over   = !count_r[31] && (count_r > SS32);
  assign cnt_full   = count_r >= SS32;
  assign rd_oor     = (m_rdata < first_blk_r) || (m_rdata >= vol_blk_r);
  assign bn_oor     = (bn_r < first_blk_r) || (bn_r >= vol_blk_r);
  assign rfl_nonpos = cnt_nonpos;

  assign in_ready = (state_r == cfba_pkg::ST_IDLE);
  assign advance  = !emit || !out_valid_r || out_ready;

  // result generation and ram control
  always_comb begin
    emit    = 1'b0;
    e_kind  = cfba_pkg::KIND_REJECT;
    e_blk   = '0;
    e_word  = '0;
    e_widx  = '0;
    e_tot   = total_r;
    e_dirty = mod_r;
    e_last  = 1'b1;
    m_we    = 1'b0;
    m_waddr = '0;
    m_wdata = '0;
    m_re    = 1'b0;
    m_raddr = '0;
    unique case (state_r)
      cfba_pkg::ST_IDLE: begin
      end
      cfba_pkg::ST_ALLOC_CHK: begin
        if (cnt_nonpos || cnt_over) begin
          emit   = 1'b1;
          e_kind = cfba_pkg::KIND_NO_SPACE;
        end else begin
          m_re    = 1'b1;
          m_raddr = cnt_dec[IDX_W-1:0];
        end
      end
      cfba_pkg::ST_ALLOC_RD: begin
        if (m_rdata == 32'd0) begin
          emit   = 1'b1;
          e_kind = cfba_pkg::KIND_NO_SPACE;
        end else if (!rd_oor) begin
          emit  = 1'b1;
          e_blk = m_rdata;
          if (count_r == 32'd0) begin
            e_kind = cfba_pkg::KIND_REQUEST;
          end else begin
            e_kind  = cfba_pkg::KIND_GRANT;
            e_tot   = total_r - 32'd1;
            e_dirty = 1'b1;
          end
        end
      end
      cfba_pkg::ST_FREE_CHK: begin
        if (bn_oor) begin
          emit   = 1'b1;
          e_kind = cfba_pkg::KIND_BAD_FREE;
          e_blk  = bn_r;
        end else if (cnt_nonpos) begin
          // empty list: entry 0 becomes the end-of-chain mark
          m_we    = 1'b1;
          m_waddr = '0;
          m_wdata = '0;
        end
      end
      cfba_pkg::ST_SPILL_CNT: begin
        emit    = 1'b1;
        e_kind  = cfba_pkg::KIND_SPILL;
        e_blk   = bn_r;
        e_word  = count_r;
        e_tot   = total_r + 32'd1;
        e_dirty = 1'b1;
        e_last  = 1'b0;
        m_re    = !out_valid_r || out_ready;
        m_raddr = '0;
      end
      cfba_pkg::ST_SPILL_RD: begin
        emit    = 1'b1;
        e_kind  = cfba_pkg::KIND_SPILL;
        e_blk   = bn_r;
        e_word  = m_rdata;
        e_widx  = 6'(idx_r) + 6'd1;
        e_tot   = total_r + 32'd1;
        e_dirty = 1'b1;
        e_last  = 1'b0;
        m_re    = (!out_valid_r || out_ready) && (idx_r != IDX_LAST);
        m_raddr = idx_r + IDX_W'(1);
      end
      cfba_pkg::ST_FREE_PUSH: begin
        emit    = 1'b1;
        e_kind  = cfba_pkg::KIND_FREED;
        e_blk   = bn_r;
        e_tot   = total_r + 32'd1;
        e_dirty = 1'b1;
        m_we    = !out_valid_r || out_ready;
        m_waddr = count_r[IDX_W-1:0];
        m_wdata = bn_r;
      end
      cfba_pkg::ST_REFILL: begin
        if (!ok_r) begin
          emit   = 1'b1;
          e_kind = cfba_pkg::KIND_NO_SPACE;
        end else begin
          if (pos_r != '0) begin
            m_we    = 1'b1;
            m_waddr = IDX_W'(pos_r - POS_W'(1));
            m_wdata = rw_r;
          end
          if (pos_r == POS_LAST) begin
            emit = 1'b1;
            if (rfl_nonpos) begin
              e_kind = cfba_pkg::KIND_NO_SPACE;
            end else begin
              e_kind  = cfba_pkg::KIND_GRANT;
              e_blk   = pblk_r;
              e_tot   = total_r - 32'd1;
              e_dirty = 1'b1;
            end
          end
        end
      end
      cfba_pkg::ST_REJECT: begin
        emit   = 1'b1;
        e_kind = cfba_pkg::KIND_REJECT;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r) inside
      cfba_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_action == cfba_pkg::ACT_ALLOC && !pend_r) begin
            state_nxt = cfba_pkg::ST_ALLOC_CHK;
          end else if (in_action == cfba_pkg::ACT_FREE && !pend_r) begin
            state_nxt = cfba_pkg::ST_FREE_CHK;
          end else if (in_action == cfba_pkg::ACT_REFILL && pend_r) begin
            state_nxt = cfba_pkg::ST_REFILL;
          end else begin
            state_nxt = cfba_pkg::ST_REJECT;
          end
        end
      end
      cfba_pkg::ST_ALLOC_CHK: begin
        if (advance) begin
          state_nxt = emit ? cfba_pkg::ST_IDLE : cfba_pkg::ST_ALLOC_RD;
        end
      end
      cfba_pkg::ST_ALLOC_RD: begin
        if (advance) begin
          // out-of-range entry: drop it and pop again
          state_nxt = emit ? cfba_pkg::ST_IDLE : cfba_pkg::ST_ALLOC_CHK;
        end
      end
      cfba_pkg::ST_FREE_CHK: begin
        if (advance) begin
          if (emit) begin
            state_nxt = cfba_pkg::ST_IDLE;
          end else if (!cnt_nonpos && cnt_full) begin
            state_nxt = cfba_pkg::ST_SPILL_CNT;
          end else begin
            state_nxt = cfba_pkg::ST_FREE_PUSH;
          end
        end
      end
      cfba_pkg::ST_SPILL_CNT: begin
        if (advance) begin
          state_nxt = cfba_pkg::ST_SPILL_RD;
        end
      end
      cfba_pkg::ST_SPILL_RD: begin
        if (advance && idx_r == IDX_LAST) begin
          state_nxt = cfba_pkg::ST_FREE_PUSH;
        end
      end
      cfba_pkg::ST_FREE_PUSH, cfba_pkg::ST_REFILL, cfba_pkg::ST_REJECT: begin
        if (advance) begin
          state_nxt = cfba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cfba_pkg::ST_IDLE;
      end
    endcase
  end

  // allocator state updates
  always_comb begin
    count_nxt = count_r;
    total_nxt = total_r;
    mod_nxt   = mod_r;
    pend_nxt  = pend_r;
    pos_nxt   = pos_r;
    pblk_nxt  = pblk_r;
    idx_nxt   = idx_r;
    if (advance) begin
      unique case (state_r)
        cfba_pkg::ST_ALLOC_CHK: begin
          count_nxt = emit ? 32'd0 : cnt_dec;
        end
        cfba_pkg::ST_ALLOC_RD: begin
          if (m_rdata == 32'd0) begin
            count_nxt = 32'd0;
          end else if (!rd_oor) begin
            if (count_r == 32'd0) begin
              pend_nxt = 1'b1;
              pos_nxt  = '0;
              pblk_nxt = m_rdata;
            end else begin
              total_nxt = total_r - 32'd1;
              mod_nxt   = 1'b1;
            end
          end
        end
        cfba_pkg::ST_FREE_CHK: begin
          if (!bn_oor && cnt_nonpos) begin
            count_nxt = 32'd1;
          end
        end
        cfba_pkg::ST_SPILL_CNT: begin
          idx_nxt = '0;
        end
        cfba_pkg::ST_SPILL_RD: begin
          if (idx_r == IDX_LAST) begin
            count_nxt = 32'd0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
        cfba_pkg::ST_FREE_PUSH: begin
          count_nxt = count_r + 32'd1;
          total_nxt = total_r + 32'd1;
          mod_nxt   = 1'b1;
        end
        cfba_pkg::ST_REFILL: begin
          if (!ok_r) begin
            pend_nxt  = 1'b0;
            pos_nxt   = '0;
            count_nxt = 32'd0;
          end else begin
            if (pos_r == '0) begin
              count_nxt = rw_r;
            end
            if (pos_r == POS_LAST) begin
              pend_nxt = 1'b0;
              pos_nxt  = '0;
              if (rfl_nonpos) begin
                count_nxt = 32'd0;
              end else begin
                total_nxt = total_r - 32'd1;
                mod_nxt   = 1'b1;
              end
            end else begin
              pos_nxt = pos_r + POS_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfba_pkg::ST_IDLE;
      first_blk_r <= '0;
      vol_blk_r   <= '0;
      count_r     <= '0;
      total_r     <= '0;
      mod_r       <= 1'b0;
      pend_r      <= 1'b0;
      pos_r       <= '0;
      pblk_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      total_r <= total_nxt;
      mod_r   <= mod_nxt;
      pend_r  <= pend_nxt;
      pos_r   <= pos_nxt;
      pblk_r  <= pblk_nxt;
      idx_r   <= idx_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          cfba_pkg::REG_FIRST_DATA_BLOCK: first_blk_r <= cfg_wdata;
          cfba_pkg::REG_VOLUME_BLOCKS:    vol_blk_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (emit && advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      bn_r <= in_block_num;
      rw_r <= in_refill_word;
      ok_r <= in_read_ok;
    end
    if (emit && advance) begin
      kind_r    <= e_kind;
      blk_res_r <= e_blk;
      word_r    <= e_word;
      widx_r    <= e_widx;
      tot_out_r <= e_tot;
      dirty_r   <= e_dirty;
      last_r    <= e_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_block_num_res = blk_res_r;
  assign out_word          = word_r;
  assign out_word_index    = widx_r;
  assign out_total_free    = tot_out_r;
  assign out_dirty         = dirty_r;
  assign out_last          = last_r;

endmodule

`default_nettype wire

// File: hdl/cfba_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module cfba_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 50,
  parameter int unsigned ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
